[hw/rtl/salc_pkg.sv]
// Shared types, constants and helpers for the set-associative LRU cache tag store.
`default_nettype none
package salc_pkg;

    localparam int MAX_SETS = 64;
    localparam int MAX_WAYS = 8;

    localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAYS_W   = $clog2(MAX_WAYS + 1);
    localparam int TAG_W    = 64;
    localparam int ADDR_W   = 64;
    localparam int CNT_W    = 32;

    localparam int SETB_W   = 3;
    localparam int BLKB_W   = 5;
    localparam int WIU_W    = 4;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int SHAMT_W  = 6;

    // access kinds
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_STORE  = 2'd1;
    localparam logic [1:0] FUNC_MODIFY = 2'd2;

    // result kinds
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_MISS  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic load;
        logic update;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [MAX_WAYS-1:0]             valid;
        logic [MAX_WAYS-1:0][RANK_W-1:0] rank;
        logic [MAX_WAYS-1:0][TAG_W-1:0]  tag;
    } row_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/set_assoc_lru_cache_sim.sv]
// Set read into the row register at accept, then lookup/write-back into the output register.
// A new access waits until the previous one is through the single tag-row read then write-back.
// An access is taken while the previous result still waits in the output register.
// Reset (aresetn, synchronous): clears control, totals, set/block bits, per-set row-valid bits;
// ways in use = 1; all lines read invalid, ranks equal to way index; no clearing pass is needed.
`default_nettype none
module set_assoc_lru_cache_sim (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_we,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  wire logic [salc_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [63:0]                    s_tdata,  // address[63:0]
    input  wire logic [1:0]                     s_tuser,  // func[1:0]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [95:0]                         m_tdata,  // total_hits, total_misses, total_evictions
    output logic [2:0]                          m_tuser   // outcome[1:0], extra_hit[2]
);
    import salc_pkg::*;

    ctrl_cmd_t        cmd;
    logic [1:0]       outcome;
    logic             extra_hit;
    logic [CNT_W-1:0] total_hits, total_misses, total_evictions;

    salc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    salc_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_func          (s_tuser),
        .s_address       (s_tdata),
        .cmd             (cmd),
        .outcome         (outcome),
        .extra_hit       (extra_hit),
        .total_hits      (total_hits),
        .total_misses    (total_misses),
        .total_evictions (total_evictions)
    );

    assign m_tdata = {total_evictions, total_misses, total_hits};
    assign m_tuser = {extra_hit, outcome};

endmodule
`default_nettype wire

[hw/rtl/salc_ctrl.sv]
// Controller: accept, lookup/write-back sequencing and output valid.
`default_nettype none
module salc_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output salc_pkg::ctrl_cmd_t     cmd
);
    import salc_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   can_update;

    assign can_update = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (can_update) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        cmd.load   = 1'b0;
        cmd.update = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_LOOKUP: begin
                cmd.update = can_update;
            end
            default: ;
        endcase
        if (cmd.update)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/salc_datapath.sv]
// Datapath: config registers, tag-row memory, way compare, LRU update and totals.
`default_nettype none
module salc_datapath (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [salc_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [salc_pkg::CFG_W-1:0]          cfg_wdata,
    input  wire logic [1:0]                          s_func,
    input  wire logic [salc_pkg::ADDR_W-1:0]         s_address,
    input  wire salc_pkg::ctrl_cmd_t                 cmd,
    output logic [1:0]                               outcome,
    output logic                                     extra_hit,
    output logic [salc_pkg::CNT_W-1:0]               total_hits,
    output logic [salc_pkg::CNT_W-1:0]               total_misses,
    output logic [salc_pkg::CNT_W-1:0]               total_evictions
);
    import salc_pkg::*;

    logic [SETB_W-1:0] set_bits_reg;
    logic [BLKB_W-1:0] block_bits_reg;
    logic [WIU_W-1:0]  ways_in_use_reg;

    row_t mem [MAX_SETS];
    row_t rd_row_reg;
    logic [MAX_SETS-1:0] row_valid_reg;

    logic [SET_W-1:0] set_idx_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [1:0]       func_reg;
    logic             row_ok_reg;

    logic [CNT_W-1:0] hit_count_reg, miss_count_reg, evict_count_reg;
    logic [1:0]       outcome_reg;
    logic             extra_hit_reg;

    // load stage
    logic [ADDR_W-1:0] shifted;
    logic [SET_W-1:0]  set_mask, set_idx;
    logic [TAG_W-1:0]  tag;

    always_comb begin
        shifted = s_address >> block_bits_reg;
        for (int i = 0; i < SET_W; i++)
            set_mask[i] = (i < int'(set_bits_reg));
        set_idx = shifted[SET_W-1:0] & set_mask;
        tag = s_address >> (SHAMT_W'(set_bits_reg) + SHAMT_W'(block_bits_reg));
    end

    // lookup stage
    logic [WAYS_W-1:0]   ways_eff;
    row_t                cur, new_row;
    logic [MAX_WAYS-1:0] in_use, hit_vec, inv_vec, zero_vec;
    logic [RANK_W-1:0]   hit_way, inv_way, zero_way, way, old_rank;
    logic [1:0]          outcome_next;
    logic [CNT_W-1:0]    hits_1, hit_count_next, miss_count_next, evict_count_next;

    always_comb begin
        if (ways_in_use_reg == '0)
            ways_eff = WAYS_W'(1);
        else if (WAYS_W'(ways_in_use_reg) > WAYS_W'(MAX_WAYS))
            ways_eff = WAYS_W'(MAX_WAYS);
        else
            ways_eff = WAYS_W'(ways_in_use_reg);

        // a row untouched since reset reads as empty, ranks equal to way index
        if (row_ok_reg) begin
            cur = rd_row_reg;
        end else begin
            cur = '0;
            for (int w = 0; w < MAX_WAYS; w++)
                cur.rank[w] = RANK_W'(w);
        end

        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w]   = WAYS_W'(w) < ways_eff;
            hit_vec[w]  = in_use[w] && cur.valid[w] && (cur.tag[w] == tag_reg);
            inv_vec[w]  = in_use[w] && !cur.valid[w];
            zero_vec[w] = in_use[w] && (cur.rank[w] == '0);
        end

        hit_way  = '0;
        inv_way  = '0;
        zero_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w])  hit_way  = RANK_W'(w);
            if (inv_vec[w])  inv_way  = RANK_W'(w);
            if (zero_vec[w]) zero_way = RANK_W'(w);
        end

        new_row = cur;
        if (|hit_vec) begin
            outcome_next = OUT_HIT;
            way          = hit_way;
        end else if (|inv_vec) begin
            outcome_next = OUT_MISS;
            way          = inv_way;
            new_row.valid[way] = 1'b1;
            new_row.tag[way]   = tag_reg;
        end else begin
            outcome_next = OUT_EVICT;
            way          = zero_way;
            new_row.tag[way] = tag_reg;
        end

        old_rank = cur.rank[way];
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (in_use[w] && (RANK_W'(w) != way) && (cur.rank[w] > old_rank))
                new_row.rank[w] = cur.rank[w] - 1'b1;
        end
        new_row.rank[way] = RANK_W'(ways_eff - 1'b1);

        hits_1 = (outcome_next == OUT_HIT) ? sat_inc(hit_count_reg) : hit_count_reg;
        hit_count_next = (func_reg == FUNC_MODIFY) ? sat_inc(hits_1) : hits_1;
        miss_count_next = (outcome_next != OUT_HIT) ? sat_inc(miss_count_reg)
                                                    : miss_count_reg;
        evict_count_next = (outcome_next == OUT_EVICT) ? sat_inc(evict_count_reg)
                                                       : evict_count_reg;
    end

    // tag-row memory: one read at accept, one write-back at update
    always_ff @(posedge aclk) begin
        if (cmd.load)
            rd_row_reg <= mem[set_idx];
        if (cmd.update)
            mem[set_idx_reg] <= new_row;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            set_idx_reg <= set_idx;
            tag_reg     <= tag;
            func_reg    <= s_func;
        end
        if (cmd.update) begin
            outcome_reg   <= outcome_next;
            extra_hit_reg <= (func_reg == FUNC_MODIFY);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            set_bits_reg    <= '0;
            block_bits_reg  <= '0;
            ways_in_use_reg <= WIU_W'(1);
            row_valid_reg   <= '0;
            row_ok_reg      <= 1'b0;
            hit_count_reg   <= '0;
            miss_count_reg  <= '0;
            evict_count_reg <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_SET_BITS:    set_bits_reg    <= cfg_wdata[SETB_W-1:0];
                    CFG_BLOCK_BITS:  block_bits_reg  <= cfg_wdata[BLKB_W-1:0];
                    CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_wdata[WIU_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.load)
                row_ok_reg <= row_valid_reg[set_idx];
            if (cmd.update) begin
                row_valid_reg[set_idx_reg] <= 1'b1;
                hit_count_reg   <= hit_count_next;
                miss_count_reg  <= miss_count_next;
                evict_count_reg <= evict_count_next;
            end
        end
    end

    assign outcome         = outcome_reg;
    assign extra_hit       = extra_hit_reg;
    assign total_hits      = hit_count_reg;
    assign total_misses    = miss_count_reg;
    assign total_evictions = evict_count_reg;

endmodule
`default_nettype wire
